// ----- rtl/named_semaphore_table_macros.svh -----
// assertion macros for the semaphore table
// no dependencies
`ifndef NAMED_SEMAPHORE_TABLE_MACROS_SVH
`define NAMED_SEMAPHORE_TABLE_MACROS_SVH
// implication checked on every clock edge outside reset
`define NST_ASSERT_IMP(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error("assertion failed");
// next-cycle implication
`define NST_ASSERT_NXT(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error("assertion failed");
`endif

// ----- rtl/nst_pkg.sv -----
// types and constants of the semaphore table
// no dependencies
package nst_pkg;
	localparam int SemSlots   = 16;
	localparam int ProcSlots  = 32;
	localparam int NameBytes  = 8;
	localparam int CountBits  = 16;
	localparam int SlotW = $clog2(SemSlots);
	localparam int PidW  = $clog2(ProcSlots);
	localparam int FillW = PidW + 1;
	localparam logic [CountBits-1:0] CountMax = '1;

	typedef enum logic [2:0] {
		K_CREATE = 3'd0, K_OPEN = 3'd1, K_CLOSE = 3'd2, K_WAIT = 3'd3,
		K_POST = 3'd4, K_DESTROY = 3'd5, K_SETVAL = 3'd6, K_READ = 3'd7
	} kind_t;

	localparam logic [2:0] ST_OK = 3'd0;
	localparam logic [2:0] ST_UNUSED = 3'd1;
	localparam logic [2:0] ST_TAKEN = 3'd2;
	localparam logic [2:0] ST_FULL = 3'd3;
	localparam logic [2:0] ST_UNKNOWN = 3'd4;
	localparam logic [2:0] ST_OVERFLOW = 3'd5;

	localparam logic [1:0] ACT_FINAL = 2'd0;
	localparam logic [1:0] ACT_BLOCKED = 2'd1;
	localparam logic [1:0] ACT_WAKE = 2'd2;

	typedef struct packed {
		logic [2:0]  kind;
		logic [3:0]  sem_index;
		logic [63:0] sem_name;
		logic [15:0] count_value;
		logic [4:0]  caller_pid;
	} req_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [1:0]  action;
		logic [3:0]  slot_out;
		logic [15:0] count_out;
		logic [4:0]  pid_out;
		logic        last;
	} rsp_t;
endpackage

// ----- rtl/nst_req_if.sv -----
// request and response channel interfaces
// depends on nst_pkg
interface nst_req_if import nst_pkg::*; ();
	logic valid;
	logic ready;
	req_t data;
	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

interface nst_rsp_if import nst_pkg::*; ();
	logic valid;
	logic ready;
	rsp_t data;
	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

// ----- rtl/named_semaphore_table.sv -----
// steps: create/open first scan the names, one slot a cycle; then the request executes;
// a blocked wait answers there, others send a word per woken process, then a final word
// throughput: one request at a time, accepted again once its last word leaves
// reset: in-use marks, queue heads and fills clear at once; names, counts,
// opened maps and the waiter memory hold anything until written
// depends on nst_pkg, nst_req_if.sv and named_semaphore_table_macros.svh
`include "named_semaphore_table_macros.svh"
module named_semaphore_table import nst_pkg::*; (
	input logic clk,
	input logic arst_n,
	nst_req_if.sink req,
	nst_rsp_if.source rsp
);
	typedef enum logic [2:0] {S_IDLE, S_SCAN, S_EXEC, S_WAKE, S_RDW, S_OUT} state_t;

	state_t state_q;
	req_t req_q;
	logic [SemSlots-1:0] in_use_q;
	logic [CountBits-1:0] count_q [SemSlots];
	logic [8*NameBytes-1:0] name_q [SemSlots];
	logic [ProcSlots-1:0] map_q [SemSlots];
	logic [PidW-1:0] head_q [SemSlots];
	logic [FillW-1:0] fill_q [SemSlots];
	logic [PidW-1:0] wmem [SemSlots*ProcSlots];
	logic [PidW-1:0] wrd_q;
	logic [SlotW:0] scan_q;
	logic found_q, free_ok_q;
	logic [SlotW-1:0] found_idx_q, free_idx_q;
	logic [CountBits:0] limit_q;
	logic [2:0] status_q;
	logic [SlotW-1:0] slot_q;
	logic [CountBits-1:0] cnt_q;
	rsp_t rsp_q;
	logic rsp_v_q;

	logic [SlotW-1:0] idx;
	logic [PidW-1:0] pid;
	logic [8*NameBytes-1:0] nm;
	logic [CountBits-1:0] val;
	logic [SlotW-1:0] sc;
	logic exec_block, exec_wake;
	assign idx = req_q.sem_index[SlotW-1:0];
	assign pid = req_q.caller_pid[PidW-1:0];
	assign nm = req_q.sem_name[8*NameBytes-1:0];
	assign val = req_q.count_value[CountBits-1:0];
	assign sc = scan_q[SlotW-1:0];

	// outcome of the request held in req_q
	assign exec_block = kind_t'(req_q.kind) == K_WAIT && in_use_q[idx] && count_q[idx] == '0;
	assign exec_wake = (kind_t'(req_q.kind) == K_POST && in_use_q[idx]
		&& count_q[idx] != CountMax) || kind_t'(req_q.kind) == K_DESTROY
		|| (kind_t'(req_q.kind) == K_SETVAL && in_use_q[idx]);

	assign req.ready = (state_q == S_IDLE) && !rsp_v_q;
	assign rsp.valid = rsp_v_q;
	assign rsp.data = rsp_q;

	always_ff @(posedge clk) begin
		if (state_q == S_EXEC && exec_block && fill_q[idx] < FillW'(ProcSlots))
			wmem[{idx, PidW'(head_q[idx] + fill_q[idx][PidW-1:0])}] <= pid;
		wrd_q <= wmem[{slot_q, head_q[slot_q]}];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			in_use_q <= '0;
			rsp_v_q <= 1'b0;
			slot_q <= '0;
			for (int i = 0; i < SemSlots; i++) begin
				head_q[i] <= '0;
				fill_q[i] <= '0;
			end
		end else begin
			if (rsp_v_q && rsp.ready && state_q != S_OUT) rsp_v_q <= 1'b0;
			case (state_q)
			S_IDLE: if (req.valid && !rsp_v_q) begin
				req_q <= req.data;
				scan_q <= '0;
				found_q <= 1'b0;
				free_ok_q <= 1'b0;
				status_q <= ST_OK;
				cnt_q <= '0;
				slot_q <= req.data.sem_index[SlotW-1:0];
				state_q <= (req.data.kind == K_CREATE || req.data.kind == K_OPEN)
					? S_SCAN : S_EXEC;
			end
			S_SCAN: begin
				if (!found_q && in_use_q[sc] && name_q[sc] == nm) begin
					found_q <= 1'b1;
					found_idx_q <= sc;
				end
				if (!free_ok_q && !in_use_q[sc]) begin
					free_ok_q <= 1'b1;
					free_idx_q <= sc;
				end
				scan_q <= scan_q + 1'b1;
				if (scan_q == (SlotW+1)'(SemSlots-1)) state_q <= S_EXEC;
			end
			S_EXEC: begin
				state_q <= exec_block ? S_IDLE : (exec_wake ? S_WAKE : S_OUT);
				case (kind_t'(req_q.kind))
				K_CREATE: if (found_q) begin
					status_q <= ST_TAKEN; slot_q <= '0;
				end else if (!free_ok_q) begin
					status_q <= ST_FULL; slot_q <= '0;
				end else begin
					in_use_q[free_idx_q] <= 1'b1;
					name_q[free_idx_q] <= nm;
					count_q[free_idx_q] <= val;
					head_q[free_idx_q] <= '0;
					fill_q[free_idx_q] <= '0;
					map_q[free_idx_q] <= ProcSlots'(1) << pid;
					slot_q <= free_idx_q;
				end
				K_OPEN: if (!found_q) begin
					status_q <= ST_UNKNOWN; slot_q <= '0;
				end else begin
					map_q[found_idx_q][pid] <= 1'b1;
					slot_q <= found_idx_q;
				end
				K_CLOSE: if (!in_use_q[idx] || !map_q[idx][pid]) status_q <= ST_UNUSED;
					else map_q[idx][pid] <= 1'b0;
				K_WAIT: if (!in_use_q[idx]) status_q <= ST_UNUSED;
					else if (count_q[idx] != '0) count_q[idx] <= count_q[idx] - 1'b1;
					else begin
						if (fill_q[idx] < FillW'(ProcSlots)) fill_q[idx] <= fill_q[idx] + 1'b1;
						rsp_q <= '{status: ST_OK, action: ACT_BLOCKED,
							slot_out: 4'(idx), count_out: '0, pid_out: 5'(pid), last: 1'b1};
						rsp_v_q <= 1'b1;
					end
				K_POST: if (!in_use_q[idx]) status_q <= ST_UNUSED;
					else if (count_q[idx] == CountMax) status_q <= ST_OVERFLOW;
					else begin
						count_q[idx] <= count_q[idx] + 1'b1;
						limit_q <= (CountBits+1)'(ProcSlots);
					end
				K_DESTROY: begin
					in_use_q[idx] <= 1'b0;
					limit_q <= (CountBits+1)'(ProcSlots);
				end
				K_SETVAL: if (!in_use_q[idx]) status_q <= ST_UNUSED;
					else begin
						count_q[idx] <= val;
						limit_q <= (val > count_q[idx])
							? {1'b0, val - count_q[idx]} : '0;
					end
				default: if (!in_use_q[idx]) status_q <= ST_UNUSED;
					else cnt_q <= count_q[idx];
				endcase
			end
			// one wake a round: read the head entry, then send it
			S_WAKE: if (!rsp_v_q || rsp.ready) begin
				if (limit_q != '0 && fill_q[slot_q] != '0) state_q <= S_RDW;
				else state_q <= S_OUT;
			end
			S_RDW: begin
				rsp_q <= '{status: ST_OK, action: ACT_WAKE, slot_out: 4'(slot_q),
					count_out: '0, pid_out: 5'(wrd_q), last: 1'b0};
				rsp_v_q <= 1'b1;
				head_q[slot_q] <= head_q[slot_q] + 1'b1;
				fill_q[slot_q] <= fill_q[slot_q] - 1'b1;
				limit_q <= limit_q - 1'b1;
				state_q <= S_WAKE;
			end
			S_OUT: if (!rsp_v_q || rsp.ready) begin
				rsp_q <= '{status: status_q, action: ACT_FINAL, slot_out: 4'(slot_q),
					count_out: 16'(cnt_q), pid_out: '0, last: 1'b1};
				rsp_v_q <= 1'b1;
				state_q <= S_IDLE;
			end
			default: state_q <= S_IDLE;
			endcase
		end
	end

	`NST_ASSERT_IMP(a_ready_idle, clk, arst_n, req.ready, state_q == S_IDLE)
	`NST_ASSERT_IMP(a_wake_not_last, clk, arst_n,
		rsp_v_q && rsp_q.action == ACT_WAKE, !rsp_q.last)
	`NST_ASSERT_NXT(a_rdw_sends, clk, arst_n, state_q == S_RDW, rsp_v_q)
	`NST_ASSERT_IMP(a_fill_bound, clk, arst_n, 1'b1,
		fill_q[slot_q] <= FillW'(ProcSlots))
endmodule
